// File: src/ttcw_pkg.sv
// ----------------------------------------------------------------------------
// ttcw_pkg
// Shared types and constants of the text terminal cell writer: command codes,
// control characters, register indexes and stream word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package ttcw_pkg;

    localparam int CMD_W        = 2;
    localparam int CHAR_W       = 8;
    localparam int CELL_INDEX_W = 11;
    localparam int CELL_W       = 16;
    localparam int COLOR_W      = 8;
    localparam int POS_W        = 11;

    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 32;
    localparam int M_PAD_W      = M_TDATA_W - CELL_W - POS_W;

    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 8;

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

    localparam logic [CFG_INDEX_W-1:0] REG_TEXT_COLOR = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STATUS_BAR = 1'd1;

    localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'd15;

    typedef struct packed {
        logic              valid;
        logic [CELL_W-1:0] cell_data;
        logic [POS_W-1:0]  cursor_pos;
    } ttcw_result_t;

endpackage

`default_nettype wire

// File: src/text_terminal_cell_writer.sv
// ----------------------------------------------------------------------------
// text_terminal_cell_writer
// Character-cell text console with put, clear and read commands over a
// stream interface, backed by a one-port-write one-port-read cell memory.
// ----------------------------------------------------------------------------
// put and unused commands: ST_DONE then the output register; read goes via ST_READ
// newline or wrap past the bottom row: scrolls up (copy
//   walk reads and writes one cell a cycle through the memory ports, then blanks)
// clear: blanks from the top text row to the last cell, one cell written per cycle
// reset clears every cell to zero, s_tready low meanwhile
// next word accepted once the result enters the output register, while it waits
`default_nettype none

module text_terminal_cell_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output      logic                                s_tready,
    // cmd[1:0], char_code[9:2], cell_index[20:10], zero pad
    input  wire logic [ttcw_pkg::S_TDATA_W-1:0]      s_tdata,
    output      logic                                m_tvalid,
    input  wire logic                                m_tready,
    // cell_data[15:0], cursor_pos[26:16], zero pad
    output      logic [ttcw_pkg::M_TDATA_W-1:0]      m_tdata,
    input  wire logic                                cfg_wr_en,
    input  wire logic [ttcw_pkg::CFG_INDEX_W-1:0]    cfg_wr_index,
    input  wire logic [ttcw_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    import ttcw_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);

    logic                  ram_wr_en;
    logic [ADDR_W-1:0]     ram_wr_addr;
    logic [CELL_W-1:0]     ram_wr_data;
    logic                  ram_rd_en;
    logic [ADDR_W-1:0]     ram_rd_addr;
    logic [CELL_W-1:0]     ram_rd_data;
    ttcw_result_t          res;
    logic                  res_take;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    ttcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .CELLS   (CELLS),
        .ADDR_W  (ADDR_W)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_cmd       (s_tdata[1:0]),
        .in_char      (s_tdata[9:2]),
        .in_index     (s_tdata[20:10]),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data),
        .ram_rd_en    (ram_rd_en),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_data  (ram_rd_data),
        .res          (res),
        .res_take     (res_take)
    );

    ttcw_cell_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W),
        .DATA_W (CELL_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign res_take = res.valid && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (res_take) begin
            m_tdata_reg <= {{M_PAD_W{1'b0}}, res.cursor_pos, res.cell_data};
        end
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_take) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// File: src/ttcw_cell_ram.sv
// ----------------------------------------------------------------------------
// ttcw_cell_ram
// Screen cell store: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcw_cell_ram #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 16
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output      logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: src/ttcw_ctrl.sv
// ----------------------------------------------------------------------------
// ttcw_ctrl
// Command sequencer: cursor and configuration registers, single cell writes,
// scroll copy walk, blank fill walk and the clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcw_ctrl #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int CELLS   = ROWS * COLUMNS,
    parameter int ADDR_W  = $clog2(CELLS)
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               in_valid,
    output      logic                               in_ready,
    input  wire logic [ttcw_pkg::CMD_W-1:0]         in_cmd,
    input  wire logic [ttcw_pkg::CHAR_W-1:0]        in_char,
    input  wire logic [ttcw_pkg::CELL_INDEX_W-1:0]  in_index,
    input  wire logic                               cfg_wr_en,
    input  wire logic [ttcw_pkg::CFG_INDEX_W-1:0]   cfg_wr_index,
    input  wire logic [ttcw_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    output      logic                               ram_wr_en,
    output      logic [ADDR_W-1:0]                  ram_wr_addr,
    output      logic [ttcw_pkg::CELL_W-1:0]        ram_wr_data,
    output      logic                               ram_rd_en,
    output      logic [ADDR_W-1:0]                  ram_rd_addr,
    input  wire logic [ttcw_pkg::CELL_W-1:0]        ram_rd_data,
    output      ttcw_pkg::ttcw_result_t             res,
    input  wire logic                               res_take
);

    import ttcw_pkg::*;

    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL     = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STRIDE    = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] SCROLL_FROM_0 = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] SCROLL_FROM_1 = ADDR_W'(2 * COLUMNS);
    localparam logic [ADDR_W-1:0] WALK_ONE      = ADDR_W'(1);
    localparam logic [ROW_W-1:0]  ROW_LAST      = ROW_W'(ROWS - 1);
    localparam logic [ROW_W-1:0]  ROW_ONE       = ROW_W'(1);
    localparam logic [COL_W-1:0]  COL_LAST      = COL_W'(COLUMNS - 1);
    localparam logic [COL_W-1:0]  COL_ONE       = COL_W'(1);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FLUSH,
        ST_BLANK,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic [ADDR_W-1:0]   walk_reg;
    logic                copy_valid_reg;
    logic [ADDR_W-1:0]   copy_addr_reg;
    logic [ROW_W-1:0]    cursor_row_reg;
    logic [COL_W-1:0]    cursor_col_reg;
    logic [COLOR_W-1:0]  text_color_reg;
    logic                status_bar_reg;
    logic                read_ok_reg;
    logic [CELL_W-1:0]   res_data_reg;

    logic                accept;
    logic                is_print;
    logic                need_adv;
    logic                last_col;
    logic                last_row;
    logic                in_range;
    logic                scroll_empty;
    logic [ROW_W-1:0]    eff_row;
    logic [ADDR_W-1:0]   cur_addr;
    logic [ADDR_W-1:0]   cursor_lin;
    logic [ADDR_W-1:0]   scroll_from;
    logic [CELL_W-1:0]   blank_cell;

    always_comb begin
        in_ready     = (state_reg == ST_IDLE);
        accept       = in_valid && in_ready;
        eff_row      = (status_bar_reg && cursor_row_reg == '0) ? ROW_ONE : cursor_row_reg;
        cur_addr     = ADDR_W'(eff_row) * ROW_STRIDE + ADDR_W'(cursor_col_reg);
        cursor_lin   = ADDR_W'(cursor_row_reg) * ROW_STRIDE + ADDR_W'(cursor_col_reg);
        is_print     = (in_cmd == CMD_PUT) && (in_char != CH_NEWLINE)
                       && (in_char != CH_RETURN);
        last_col     = (cursor_col_reg == COL_LAST);
        last_row     = (eff_row == ROW_LAST);
        need_adv     = (in_cmd == CMD_PUT)
                       && ((in_char == CH_NEWLINE) || (is_print && last_col));
        in_range     = (32'(in_index) < 32'(CELLS));
        scroll_empty = status_bar_reg && (ROWS == 2);
        scroll_from  = status_bar_reg ? SCROLL_FROM_1 : SCROLL_FROM_0;
        blank_cell   = {text_color_reg, CH_SPACE};

        ram_wr_en   = 1'b0;
        ram_wr_addr = walk_reg;
        ram_wr_data = blank_cell;
        if (copy_valid_reg) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = copy_addr_reg;
            ram_wr_data = ram_rd_data;
        end else if (state_reg == ST_INIT) begin
            ram_wr_en   = 1'b1;
            ram_wr_data = '0;
        end else if (state_reg == ST_BLANK) begin
            ram_wr_en   = 1'b1;
        end else if (accept && is_print) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cur_addr;
            ram_wr_data = {text_color_reg, in_char};
        end

        ram_rd_en   = (state_reg == ST_SCROLL) || (accept && in_cmd == CMD_READ);
        ram_rd_addr = (state_reg == ST_SCROLL) ? walk_reg : ADDR_W'(in_index);

        res.valid      = (state_reg == ST_DONE);
        res.cell_data  = res_data_reg;
        res.cursor_pos = POS_W'(cursor_lin);
    end

    always_ff @(posedge aclk) begin
        copy_addr_reg <= walk_reg - ROW_STRIDE;
        if (!aresetn) begin
            state_reg      <= ST_INIT;
            walk_reg       <= '0;
            copy_valid_reg <= 1'b0;
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
            text_color_reg <= TEXT_COLOR_RESET;
            status_bar_reg <= 1'b0;
        end else begin
            copy_valid_reg <= (state_reg == ST_SCROLL);

            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_TEXT_COLOR: begin
                        text_color_reg <= cfg_wr_data;
                    end
                    REG_STATUS_BAR: begin
                        status_bar_reg <= cfg_wr_data[0];
                        if (cfg_wr_data[0] && cursor_row_reg == '0) begin
                            cursor_row_reg <= ROW_ONE;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            case (state_reg)
                ST_INIT: begin
                    walk_reg <= walk_reg + WALK_ONE;
                    if (walk_reg == LAST_CELL) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        res_data_reg <= '0;
                        case (in_cmd)
                            CMD_PUT: begin
                                if (need_adv) begin
                                    cursor_col_reg <= '0;
                                    if (last_row) begin
                                        cursor_row_reg <= ROW_LAST;
                                        if (scroll_empty) begin
                                            walk_reg  <= LAST_ROW_BASE;
                                            state_reg <= ST_BLANK;
                                        end else begin
                                            walk_reg  <= scroll_from;
                                            state_reg <= ST_SCROLL;
                                        end
                                    end else begin
                                        cursor_row_reg <= eff_row + ROW_ONE;
                                        state_reg      <= ST_DONE;
                                    end
                                end else begin
                                    cursor_row_reg <= eff_row;
                                    if (is_print) begin
                                        cursor_col_reg <= cursor_col_reg + COL_ONE;
                                    end else begin
                                        cursor_col_reg <= '0;
                                    end
                                    state_reg <= ST_DONE;
                                end
                            end
                            CMD_CLEAR: begin
                                cursor_row_reg <= status_bar_reg ? ROW_ONE : '0;
                                cursor_col_reg <= '0;
                                walk_reg       <= status_bar_reg ? ROW_STRIDE : '0;
                                state_reg      <= ST_BLANK;
                            end
                            CMD_READ: begin
                                read_ok_reg <= in_range;
                                state_reg   <= ST_READ;
                            end
                            default: begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_READ: begin
                    res_data_reg <= read_ok_reg ? ram_rd_data : '0;
                    state_reg    <= ST_DONE;
                end
                ST_SCROLL: begin
                    walk_reg <= walk_reg + WALK_ONE;
                    if (walk_reg == LAST_CELL) begin
                        state_reg <= ST_FLUSH;
                    end
                end
                ST_FLUSH: begin
                    walk_reg  <= LAST_ROW_BASE;
                    state_reg <= ST_BLANK;
                end
                ST_BLANK: begin
                    walk_reg <= walk_reg + WALK_ONE;
                    if (walk_reg == LAST_CELL) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (res_take) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cursor_col_reg) < 32'(COLUMNS))
        else $error("cursor column out of range");

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cursor_row_reg) < 32'(ROWS))
        else $error("cursor row out of range");

    a_read_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_cmd == CMD_READ) |=> (state_reg == ST_READ))
        else $error("read command did not enter read state");

    a_take_done: assert property (@(posedge aclk) disable iff (!aresetn)
        res_take |-> (state_reg == ST_DONE))
        else $error("result taken with no result pending");

    a_copy_scope: assert property (@(posedge aclk) disable iff (!aresetn)
        copy_valid_reg |-> (state_reg == ST_SCROLL || state_reg == ST_FLUSH))
        else $error("copy write outside scroll");

endmodule

`default_nettype wire
